[design/clocked_serial_read_responder_top_assert.svh]
// Assertion macros used by the serial read responder RTL.
`ifndef CLOCKED_SERIAL_READ_RESPONDER_TOP_ASSERT_SVH
`define CLOCKED_SERIAL_READ_RESPONDER_TOP_ASSERT_SVH

`ifndef SYNTH

// Property that must hold at every clock edge outside reset.
`define CRSR_ASSERT(lbl, clk, rst_n, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
    else $error("crsr assertion failed");

// Condition that must never be true outside reset.
`define CRSR_NEVER(lbl, clk, rst_n, cond) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
    else $error("crsr forbidden condition seen");

`else

`define CRSR_ASSERT(lbl, clk, rst_n, prop)

`define CRSR_NEVER(lbl, clk, rst_n, cond)

`endif

`endif

[design/crsr_pkg.sv]
// Package with types, constants and helpers of the serial read responder.
`default_nettype none

package crsr_pkg;

  // Reply length in bits and the width of the bit counter.
  localparam int unsigned REPLY_BITS = 40;
  localparam int unsigned CNT_W      = 6;
  localparam int unsigned FRAME_W    = 16;
  localparam int unsigned CFG_IDX_W  = 8;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] CFG_HEADER_MARK  = 8'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_READ_COMMAND = 8'd1;

  // Configuration reset values.
  localparam logic [7:0] HEADER_MARK_RST  = 8'hCC;
  localparam logic [7:0] READ_COMMAND_RST = 8'h01;

  // One request: a bus clock edge with its data bit and the measurement.
  typedef struct packed {
    logic        in_bit;
    logic [31:0] measurement;
  } in_item_t;

  // One result: line level and the replying flag after the edge.
  typedef struct packed {
    logic out_bit;
    logic sending;
  } out_item_t;

  // Current configuration register values.
  typedef struct packed {
    logic [7:0] header_mark;
    logic [7:0] read_command;
  } cfg_t;

  // Engine status seen by the top level.
  typedef struct packed {
    logic             reply_active;
    logic [CNT_W-1:0] bit_count;
  } status_t;

  // Reply word: the measurement bytes followed by their 8-bit sum.
  function automatic logic [REPLY_BITS-1:0] reply_build(input logic [31:0] meas);
    logic [7:0] sum;
    sum = meas[31:24] + meas[23:16] + meas[15:8] + meas[7:0];
    return {meas, sum};
  endfunction

endpackage

`default_nettype wire

[design/crsr_cfg_regs.sv]
// Configuration registers of the serial read responder.
`default_nettype none

module crsr_cfg_regs
  import crsr_pkg::*;
(
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 cfg_valid,
  output logic                      cfg_ready,
  input  wire logic [CFG_IDX_W-1:0] cfg_index,
  input  wire logic [7:0]           cfg_wdata,
  output cfg_t                      cfg
);

  logic [7:0] header_mark_r;
  logic [7:0] read_command_r;

  // Writes are always taken; unknown indexes are dropped.
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      header_mark_r  <= HEADER_MARK_RST;
      read_command_r <= READ_COMMAND_RST;
    end else if (cfg_valid) begin
      case (cfg_index)
        CFG_HEADER_MARK:  header_mark_r  <= cfg_wdata;
        CFG_READ_COMMAND: read_command_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  assign cfg.header_mark  = header_mark_r;
  assign cfg.read_command = read_command_r;

endmodule

`default_nettype wire

[design/crsr_in_stage.sv]
// Input register stage that holds one request for the engine.
`default_nettype none

module crsr_in_stage
  import crsr_pkg::*;
(
  input  wire logic     clk,
  input  wire logic     rst_n,
  input  wire logic     in_valid,
  output logic          in_stall,
  input  wire in_item_t in_data,
  input  wire logic     take,
  output logic          stg_valid,
  output in_item_t      stg_data
);

  logic     valid_r;
  logic     valid_nxt;
  in_item_t data_r;
  logic     accept;

  // The stage refills in the same cycle that the engine takes its request.
  assign in_stall = valid_r && !take;
  assign accept   = in_valid && !in_stall;

  always_comb begin
    valid_nxt = valid_r;
    if (accept) begin
      valid_nxt = 1'b1;
    end else if (take) begin
      valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  // Payload needs no reset.
  always_ff @(posedge clk) begin
    if (accept) begin
      data_r <= in_data;
    end
  end

  assign stg_valid = valid_r;
  assign stg_data  = data_r;

endmodule

`default_nettype wire

[design/crsr_engine.sv]
// Frame matching, reply shifting and the result register.
`default_nettype none

module crsr_engine
  import crsr_pkg::*;
(
  input  wire logic     clk,
  input  wire logic     rst_n,
  input  wire cfg_t     cfg,
  input  wire logic     stg_valid,
  input  wire in_item_t stg_data,
  output logic          take,
  output logic          out_valid,
  input  wire logic     out_stall,
  output out_item_t     out_data,
  output status_t       status
);

  logic [FRAME_W-1:0]    frame_r, frame_nxt;
  logic                  active_r, active_nxt;
  logic [CNT_W-1:0]      cnt_r, cnt_nxt;
  logic [REPLY_BITS-1:0] reply_r, reply_nxt;
  logic                  line_r, line_nxt;
  logic                  out_valid_r;
  out_item_t             out_data_r;
  logic [FRAME_W-1:0]    shifted;

  // A request moves on when the result register is empty or being drained.
  assign take = stg_valid && (!out_valid_r || !out_stall);

  // Next state for one bus clock edge.
  always_comb begin
    frame_nxt  = frame_r;
    active_nxt = active_r;
    cnt_nxt    = cnt_r;
    reply_nxt  = reply_r;
    line_nxt   = line_r;
    shifted    = {frame_r[FRAME_W-2:0], stg_data.in_bit};
    if (!active_r) begin
      frame_nxt = shifted;
      if (shifted[15:8] == cfg.header_mark && shifted[7:0] == cfg.read_command) begin
        reply_nxt  = reply_build(stg_data.measurement);
        cnt_nxt    = '0;
        active_nxt = 1'b1;
      end
    end else if (cnt_r < CNT_W'(REPLY_BITS)) begin
      line_nxt  = reply_r[REPLY_BITS-1];
      reply_nxt = {reply_r[REPLY_BITS-2:0], 1'b0};
      cnt_nxt   = cnt_r + 1'b1;
    end else begin
      line_nxt   = 1'b1;
      cnt_nxt    = '0;
      active_nxt = 1'b0;
    end
  end

  // Control state and the result valid flag.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      frame_r     <= '0;
      active_r    <= 1'b0;
      cnt_r       <= '0;
      line_r      <= 1'b1;
      out_valid_r <= 1'b0;
    end else begin
      if (take) begin
        frame_r  <= frame_nxt;
        active_r <= active_nxt;
        cnt_r    <= cnt_nxt;
        line_r   <= line_nxt;
      end
      if (take) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Reply buffer and result payload need no reset.
  always_ff @(posedge clk) begin
    if (take) begin
      reply_r            <= reply_nxt;
      out_data_r.out_bit <= line_nxt;
      out_data_r.sending <= active_nxt;
    end
  end

  assign out_valid           = out_valid_r;
  assign out_data            = out_data_r;
  assign status.reply_active = active_r;
  assign status.bit_count    = cnt_r;

endmodule

`default_nettype wire

[design/clocked_serial_read_responder_top.sv]
// Top level of the clocked serial read responder.
`default_nettype none

`include "clocked_serial_read_responder_top_assert.svh"

// Slave end of a clocked serial link: each request is one bus clock edge with
// the sampled data bit and the current measurement; each request yields one
// result with the output line level and the replying flag after that edge.
// A 16-bit frame whose upper byte matches header_mark (register 0) and lower
// byte matches read_command (register 1) captures a 40-bit reply, the four
// measurement bytes then their 8-bit sum, sent most significant bit first on
// the following edges, one bit per edge; the edge after the last bit releases
// the line high. A request is taken every cycle unless the output stalls; its
// result goes via the input register, one engine pass and the result register.
module clocked_serial_read_responder_top
  import crsr_pkg::*;
(
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 in_valid,
  output logic                      in_stall,
  input  wire in_item_t             in_data,
  output logic                      out_valid,
  input  wire logic                 out_stall,
  output out_item_t                 out_data,
  input  wire logic                 cfg_valid,
  output logic                      cfg_ready,
  input  wire logic [CFG_IDX_W-1:0] cfg_index,
  input  wire logic [7:0]           cfg_wdata
);

  cfg_t     cfg;
  logic     stg_valid;
  in_item_t stg_data;
  logic     take;
  status_t  status;

  // Configuration registers.
  crsr_cfg_regs u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .cfg       (cfg)
  );

  // Input register.
  crsr_in_stage u_in (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .take      (take),
    .stg_valid (stg_valid),
    .stg_data  (stg_data)
  );

  // Engine with the result register.
  crsr_engine u_eng (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg),
    .stg_valid (stg_valid),
    .stg_data  (stg_data),
    .take      (take),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .status    (status)
  );

  // The bit counter never passes the reply length.
  `CRSR_NEVER(a_cnt_range, clk, rst_n, status.bit_count > CNT_W'(REPLY_BITS))
  // While idle the bit counter rests at zero.
  `CRSR_ASSERT(a_idle_cnt, clk, rst_n, !status.reply_active |-> status.bit_count == '0)
  // A request handed to the engine shows up as a result in the next cycle.
  `CRSR_ASSERT(a_take_out, clk, rst_n, take |=> out_valid)
  // The input side only stalls while the input register is occupied.
  `CRSR_ASSERT(a_stall_full, clk, rst_n, in_stall |-> stg_valid)

endmodule

`default_nettype wire
